// ===== sv/ssc_pkg.sv =====
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned NUM_STEPS  = 6;

  // Item kinds
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SPEED      = 2'd0,
    CFG_ZC_THRESHOLD   = 2'd1,
    CFG_SETTLE_TICKS   = 2'd2,
    CFG_SPEED_FRAME_ID = 2'd3
  } cfg_idx_t;

  typedef logic [5:0]  gates_t;
  typedef logic [2:0]  step_t;
  typedef logic [9:0]  sample_t;
  typedef logic [15:0] speed_t;
  typedef logic [10:0] frame_id_t;
  typedef logic [31:0] ticks_t;
  typedef logic [29:0] step_time_t;
  typedef logic [39:0] on_prod_t;

  // Register reset values
  localparam logic [9:0] MIN_SPEED_RST      = 10'd100;
  localparam sample_t    ZC_THRESHOLD_RST   = 10'd512;
  localparam logic [7:0] SETTLE_TICKS_RST   = 8'd10;
  localparam frame_id_t  SPEED_FRAME_ID_RST = 11'h123;

  localparam speed_t     FULL_SPEED    = 16'd1000;
  // Step time is period / 6; period saturates at all-ones, so step time tops out here
  localparam step_time_t STEP_TIME_SAT = 30'(32'hFFFF_FFFF / NUM_STEPS);
  localparam step_time_t STEP_TIME_RST = 30'(1000000 / NUM_STEPS);
  localparam step_t      LAST_STEP     = 3'(NUM_STEPS - 1);

  typedef struct packed {
    gates_t gates;
    step_t  step_now;
    logic   commutated;
    logic   zero_cross;
  } res_t;

  // Gate pattern per step: bit 0 AH, 1 AL, 2 BH, 3 BL, 4 CH, 5 CL
  function automatic gates_t step_gates(input step_t step);
    gates_t g;
    unique case (step)
      3'd0:    g = 6'h09;
      3'd1:    g = 6'h21;
      3'd2:    g = 6'h24;
      3'd3:    g = 6'h06;
      3'd4:    g = 6'h12;
      3'd5:    g = 6'h18;
      default: g = 6'h00;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/ssc_if.sv =====
`timescale 1ns / 1ps

interface ssc_in_if;
  import ssc_pkg::*;
  logic      valid;
  logic      ready;
  logic      op;
  frame_id_t frame_id;
  speed_t    speed_value;
  sample_t   bemf_a;
  sample_t   bemf_b;
  sample_t   bemf_c;

  modport source (output valid, op, frame_id, speed_value, bemf_a, bemf_b, bemf_c,
                  input ready);
  modport sink   (input valid, op, frame_id, speed_value, bemf_a, bemf_b, bemf_c,
                  output ready);
endinterface

interface ssc_out_if;
  import ssc_pkg::*;
  logic   valid;
  logic   ready;
  gates_t gates;
  step_t  step_now;
  logic   commutated;
  logic   zero_cross;

  modport source (output valid, gates, step_now, commutated, zero_cross, input ready);
  modport sink   (input valid, gates, step_now, commutated, zero_cross, output ready);
endinterface

// ===== sv/sensorless_six_step_commutator_core.sv =====
`timescale 1ns / 1ps

// Sensorless six-step BLDC commutator. Every input transaction yields exactly one
// result transaction. A tick (op 0) counts one microsecond, advances the step when
// the step time (period / 6) has run out, samples the floating phase's back-EMF on
// every tick once settle_ticks have passed since commutation, and cuts the gates
// once the on time (step time * speed / 1000) is reached when speed is below 1000.
// A speed frame (op 1) with a matching identifier stores the speed; its result
// repeats the current gates and step. Throughput is one transaction per clock while
// the skid register is empty: all tick work sits between the input handshake and
// the result register, and the step time * speed product is kept registered so
// that a tick only compares against it. Each result is registered; a two-entry
// output (result register plus skid register) keeps in_ch.ready high while one
// result waits for the sink. Configuration writes take effect on the next clock.
module sensorless_six_step_commutator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  ssc_in_if.sink                           in_ch,
  ssc_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ssc_pkg::*;

  // Configuration registers
  logic [9:0] min_speed_r;
  sample_t    zc_threshold_r;
  logic [7:0] settle_ticks_r;
  frame_id_t  speed_frame_id_r;

  // Motor state
  step_t      step_r,      step_nxt;
  ticks_t     elapsed_r,   elapsed_nxt;
  step_time_t step_time_r, step_time_nxt;
  on_prod_t   on_prod_r,   on_prod_nxt;
  speed_t     speed_r,     speed_nxt;
  sample_t    last_r,      last_nxt;
  gates_t     gate_r,      gate_nxt;

  // Output stage
  logic out_v_r,  out_v_nxt;
  res_t out_d_r,  out_d_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t skid_d_r, skid_d_nxt;

  logic       in_acc;
  logic       out_fire;
  res_t       res;
  ticks_t     elapsed_inc;
  sample_t    sample;
  logic [41:0] ticks_x1000;

  assign in_ch.ready = !skid_v_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_fire    = out_v_r && out_ch.ready;

  // Configuration: plain write port, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_speed_r      <= MIN_SPEED_RST;
      zc_threshold_r   <= ZC_THRESHOLD_RST;
      settle_ticks_r   <= SETTLE_TICKS_RST;
      speed_frame_id_r <= SPEED_FRAME_ID_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_SPEED:      min_speed_r      <= cfg_wdata[9:0];
        CFG_ZC_THRESHOLD:   zc_threshold_r   <= cfg_wdata[9:0];
        CFG_SETTLE_TICKS:   settle_ticks_r   <= cfg_wdata[7:0];
        CFG_SPEED_FRAME_ID: speed_frame_id_r <= cfg_wdata;
      endcase
    end
  end

  // Saturating tick count
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 32'd1;

  // Per-transaction work
  always_comb begin
    step_nxt      = step_r;
    elapsed_nxt   = elapsed_r;
    step_time_nxt = step_time_r;
    speed_nxt     = speed_r;
    last_nxt      = last_r;
    gate_nxt      = gate_r;
    sample        = in_ch.bemf_a;
    ticks_x1000   = '0;
    res.commutated = 1'b0;
    res.zero_cross = 1'b0;

    if (in_acc) begin
      if (in_ch.op == OP_FRAME) begin
        if (in_ch.frame_id == speed_frame_id_r) begin
          speed_nxt = in_ch.speed_value;
        end
      end else begin
        elapsed_nxt = elapsed_inc;
        if (speed_r < {6'd0, min_speed_r}) begin
          // Below minimum speed: keep counting ticks, hold the rest, drop the gates
          gate_nxt = '0;
        end else begin
          // Advance the step once the step time has run out
          if (elapsed_inc >= {2'd0, step_time_r}) begin
            step_nxt       = (step_r >= LAST_STEP) ? 3'd0 : step_r + 3'd1;
            elapsed_nxt    = '0;
            gate_nxt       = step_gates(step_nxt);
            res.commutated = 1'b1;
          end

          // Watch the floating phase on every tick past the settle time
          if (elapsed_nxt >= {24'd0, settle_ticks_r} && step_nxt <= LAST_STEP) begin
            unique case (step_nxt)
              3'd0, 3'd3: sample = in_ch.bemf_c;
              3'd1, 3'd4: sample = in_ch.bemf_b;
              default:    sample = in_ch.bemf_a;
            endcase
            if ((last_r >= zc_threshold_r) != (sample >= zc_threshold_r)) begin
              res.zero_cross = 1'b1;
              // New period is elapsed * 6 (saturating), so step time is elapsed
              step_time_nxt = (elapsed_nxt > {2'd0, STEP_TIME_SAT}) ?
                              STEP_TIME_SAT : elapsed_nxt[29:0];
            end
            last_nxt = sample;
          end

          // On-time cut: elapsed >= floor(prod / 1000) <=> (elapsed + 1) * 1000 > prod.
          // After a fresh crossing the new on time never exceeds elapsed, so cut.
          if (speed_r < FULL_SPEED) begin
            ticks_x1000 = (42'(elapsed_nxt) + 42'd1) * 42'd1000;
            if (res.zero_cross || ticks_x1000 > {2'd0, on_prod_r}) begin
              gate_nxt = '0;
            end
          end
        end
      end
    end

    res.gates    = gate_nxt;
    res.step_now = step_nxt;
  end

  // Keep step time * speed ready for the next tick
  assign on_prod_nxt = 40'(step_time_nxt) * 40'(speed_nxt[9:0]);

  // Output register with skid register behind it
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_fire) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = in_acc;
        out_d_nxt = res;
      end
    end else if (in_acc) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      elapsed_r   <= '0;
      step_time_r <= STEP_TIME_RST;
      on_prod_r   <= '0;
      speed_r     <= '0;
      last_r      <= '0;
      gate_r      <= '0;
      out_v_r     <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      elapsed_r   <= elapsed_nxt;
      step_time_r <= step_time_nxt;
      on_prod_r   <= on_prod_nxt;
      speed_r     <= speed_nxt;
      last_r      <= last_nxt;
      gate_r      <= gate_nxt;
      out_v_r     <= out_v_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.gates      = out_d_r.gates;
  assign out_ch.step_now   = out_d_r.step_now;
  assign out_ch.commutated = out_d_r.commutated;
  assign out_ch.zero_cross = out_d_r.zero_cross;

endmodule

// ===== sv/ssc_checker.sv =====
`timescale 1ns / 1ps

module ssc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ssc_pkg::gates_t     out_gates,
  input ssc_pkg::step_t      out_step_now,
  input logic                out_commutated,
  input logic                out_zero_cross
);
  import ssc_pkg::*;

  // Leave reset with nothing pending and room for a transaction
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result pending or input blocked after reset");

  // Input may only stall while a result is waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gates) &&
      $stable(out_step_now) && $stable(out_commutated) && $stable(out_zero_cross))
    else $error("stalled result changed");

  // Gates are either off or exactly the reported step's pattern
  a_gates_match_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gates != '0 |-> out_gates == step_gates(out_step_now))
    else $error("gate pattern does not match step");

  // A commutation never reports a step outside the six valid ones
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_commutated |-> out_step_now <= LAST_STEP)
    else $error("commutation to an invalid step");

endmodule

bind sensorless_six_step_commutator_core ssc_checker u_ssc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_gates      (out_ch.gates),
  .out_step_now   (out_ch.step_now),
  .out_commutated (out_ch.commutated),
  .out_zero_cross (out_ch.zero_cross)
);

// ===== tb/sv/commutator_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each drive result and
// compares it with what the commutator returns.
module commutator_checker import ssc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ssc_in_if                     in_mon,
  ssc_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           pending
);

  localparam int unsigned PHASES       = 6;
  localparam int unsigned FULL_ON      = 1000;
  localparam ticks_t      PERIOD_RESET = 32'd1000000;
  localparam gates_t      PHASE_DRIVE [8] = '{6'h09, 6'h21, 6'h24, 6'h06,
                                              6'h12, 6'h18, 6'h00, 6'h00};

  // Register copies
  logic [9:0] c_min;
  sample_t    c_thr;
  logic [7:0] c_settle;
  frame_id_t  c_fid;

  // Motor state
  step_t   m_step;
  ticks_t  m_elapsed;
  ticks_t  m_period;
  speed_t  m_speed;
  sample_t m_last;
  gates_t  m_gates;

  res_t        drive_q [$];
  int unsigned fail_cnt = 0;

  function automatic res_t advance_motor(input logic op, input frame_id_t fid,
                                         input speed_t spd, input sample_t a,
                                         input sample_t b, input sample_t c);
    res_t        r;
    ticks_t      step_time;
    sample_t     s;
    logic [34:0] p6;
    logic [47:0] on_t;
    r = '0;
    if (op == OP_FRAME) begin
      if (fid == c_fid) m_speed = spd;
    end else begin
      if (m_elapsed != '1) m_elapsed = m_elapsed + 32'd1;
      if (m_speed < 16'(c_min)) begin
        m_gates = '0;
      end else begin
        step_time = m_period / PHASES;
        if (m_elapsed >= step_time) begin
          m_step       = (m_step >= 3'd5) ? 3'd0 : m_step + 3'd1;
          m_elapsed    = '0;
          m_gates      = PHASE_DRIVE[m_step];
          r.commutated = 1'b1;
        end
        if (m_elapsed >= 32'(c_settle) && m_step < 3'(PHASES)) begin
          // sample the floating phase
          case (m_step)
            3'd0, 3'd3: s = c;
            3'd1, 3'd4: s = b;
            default:    s = a;
          endcase
          if ((m_last >= c_thr) != (s >= c_thr)) begin
            p6           = 35'(m_elapsed) * 35'(PHASES);
            m_period     = (p6 > 35'h0_FFFF_FFFF) ? '1 : p6[31:0];
            r.zero_cross = 1'b1;
          end
          m_last = s;
        end
        if (m_speed < 16'(FULL_ON)) begin
          on_t = 48'(m_period / PHASES) * 48'(m_speed) / 48'(FULL_ON);
          if (48'(m_elapsed) >= on_t) m_gates = '0;
        end
      end
    end
    r.gates    = m_gates;
    r.step_now = m_step;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      c_min     = MIN_SPEED_RST;
      c_thr     = ZC_THRESHOLD_RST;
      c_settle  = SETTLE_TICKS_RST;
      c_fid     = SPEED_FRAME_ID_RST;
      m_step    = '0;
      m_elapsed = '0;
      m_period  = PERIOD_RESET;
      m_speed   = '0;
      m_last    = '0;
      m_gates   = '0;
      drive_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIN_SPEED:      c_min    = cfg_wdata[9:0];
          CFG_ZC_THRESHOLD:   c_thr    = cfg_wdata[9:0];
          CFG_SETTLE_TICKS:   c_settle = cfg_wdata[7:0];
          CFG_SPEED_FRAME_ID: c_fid    = cfg_wdata[10:0];
          default: ;
        endcase
      end
      // a result leaving now belongs to an earlier transaction: pop before push
      if (out_mon.valid && out_mon.ready) begin
        if (drive_q.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual gates %0d step %0d",
                   $time, out_mon.gates, out_mon.step_now);
          fail_cnt++;
        end else begin
          want = drive_q.pop_front();
          check_field("gates", want.gates, out_mon.gates);
          check_field("step_now", want.step_now, out_mon.step_now);
          check_field("commutated", want.commutated, out_mon.commutated);
          check_field("zero_cross", want.zero_cross, out_mon.zero_cross);
        end
      end
      if (in_mon.valid && in_mon.ready)
        drive_q.push_back(advance_motor(in_mon.op, in_mon.frame_id, in_mon.speed_value,
                                        in_mon.bemf_a, in_mon.bemf_b, in_mon.bemf_c));
    end
    pending    <= drive_q.size();
    mismatches <= fail_cnt;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the sensorless six-step commutator. The checker beside
// the block does all prediction; this module only feeds transactions, idles both
// channels, reprograms the registers between phases and calls the result.
module tb;
  import ssc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 235;
  localparam int unsigned NUM_PHASES  = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ssc_in_if  in_ch ();
  ssc_out_if out_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  // Shared between the two sides: when set, neither side idles
  bit no_gaps = 1'b0;

  // Settings as last written, used to shape the back-EMF and speed values
  int unsigned cur_min = MIN_SPEED_RST;
  int unsigned cur_thr = ZC_THRESHOLD_RST;
  frame_id_t   cur_fid = SPEED_FRAME_ID_RST;

  // Back-EMF side of the threshold, flipped now and then to force crossings;
  // flip_odds sets how long it stays put, and so how long the period grows
  bit          bemf_high = 1'b0;
  int unsigned flip_odds = 6;

  sensorless_six_step_commutator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  commutator_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    return no_gaps ? 0 : $urandom_range(0, 4);
  endfunction

  // Pick a sample mostly on the current side of the threshold, sometimes anywhere
  function automatic sample_t pick_bemf();
    if ($urandom_range(0, 9) < 4) return sample_t'($urandom);
    if (bemf_high) return sample_t'($urandom_range(cur_thr, 1023));
    return (cur_thr == 0) ? '0 : sample_t'($urandom_range(0, cur_thr - 1));
  endfunction

  // Offer one transaction and hold it until accepted. Valid is only lowered when
  // a gap follows, so it never drops and rises within one step.
  task automatic send(input logic op, input frame_id_t fid, input speed_t spd,
                      input sample_t a, input sample_t b, input sample_t c);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.frame_id    <= fid;
    in_ch.speed_value <= spd;
    in_ch.bemf_a      <= a;
    in_ch.bemf_b      <= b;
    in_ch.bemf_c      <= c;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every result to drain, then allow for the pipeline
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned min_spd, input int unsigned thr,
                              input int unsigned settle, input int unsigned fid);
    put_reg(CFG_MIN_SPEED, min_spd);
    put_reg(CFG_ZC_THRESHOLD, thr);
    put_reg(CFG_SETTLE_TICKS, settle);
    put_reg(CFG_SPEED_FRAME_ID, fid);
    cfg_we  <= 1'b0;
    cur_min = min_spd;
    cur_thr = thr;
    cur_fid = frame_id_t'(fid);
  endtask

  // Mostly ticks with threshold-aware back-EMF; frames mostly carry the live id
  task automatic random_item();
    speed_t    spd;
    frame_id_t fid;
    if ($urandom_range(0, 99) < 85) begin
      if ($urandom_range(1, flip_odds) == 1) bemf_high = !bemf_high;
      send(OP_TICK, frame_id_t'($urandom), speed_t'($urandom),
           pick_bemf(), pick_bemf(), pick_bemf());
    end else begin
      case ($urandom_range(0, 7))
        0:       spd = (cur_min == 0) ? '0 : speed_t'($urandom_range(0, cur_min - 1));
        1, 2:    spd = speed_t'($urandom_range(cur_min, 999));
        3:       spd = speed_t'(1000);
        4:       spd = '1;
        5:       spd = speed_t'($urandom);
        default: spd = speed_t'($urandom_range(cur_min, 1100));
      endcase
      fid = ($urandom_range(0, 3) == 0) ? frame_id_t'($urandom) : cur_fid;
      send(OP_FRAME, fid, spd, sample_t'($urandom), sample_t'($urandom),
           sample_t'($urandom));
    end
  endtask

  // Result side: stall for a random number of cycles, then take one transaction
  initial begin : sink_side
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = gap_len();
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_TICK;
    in_ch.frame_id    <= '0;
    in_ch.speed_value <= '0;
    in_ch.bemf_a      <= '0;
    in_ch.bemf_b      <= '0;
    in_ch.bemf_c      <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_MIN_SPEED;
    cfg_wdata         <= '0;
    rst_n             <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset settings. Speed is still zero: gates stay off.
    send(OP_TICK, '0, '0, '0, '0, '0);
    // Foreign identifier with the largest speed: must change nothing
    send(OP_FRAME, '1, '1, '1, '1, '1);
    // Live identifier, one below the minimum: still off
    send(OP_FRAME, SPEED_FRAME_ID_RST, 16'd99, '0, '0, '0);
    send(OP_TICK, '1, '1, '1, '1, '1);
    // Exactly the minimum speed
    send(OP_FRAME, SPEED_FRAME_ID_RST, 16'd100, '0, '0, '0);
    // Phase C held high: a crossing once the settle time has run, which sets the step
    // time to the ticks elapsed, so the step advances within this run
    repeat (10) send(OP_TICK, '0, '0, '0, '0, '1);
    // Step time not yet run out again: no commutation
    send(OP_TICK, '0, '0, '0, '0, '1);
    // Full speed after a cut: gates must stay off until the next commutation
    send(OP_FRAME, SPEED_FRAME_ID_RST, 16'd1000, '0, '0, '0);
    repeat (6) send(OP_TICK, '0, '0, '1, '0, '1);
    send(OP_FRAME, SPEED_FRAME_ID_RST, '1, '0, '0, '0);
    send(OP_TICK, '1, '1, '0, '0, '0);

    // Random phases, each under its own settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      case (ph)
        // no minimum, top threshold, no settle: period collapses, step every tick
        0:       program_regs(0, 1023, 0, 0);
        // minimum past full speed, threshold zero so nothing crosses, longest settle
        1:       program_regs(1023, 0, 255, 2047);
        2:       program_regs(1000, 512, 255, 2047);
        3:       program_regs(MIN_SPEED_RST, ZC_THRESHOLD_RST, SETTLE_TICKS_RST,
                              SPEED_FRAME_ID_RST);
        default: program_regs($urandom_range(0, 1000), $urandom_range(0, 1023),
                              $urandom_range(0, 30), $urandom_range(0, 2047));
      endcase
      case ($urandom_range(0, 3))
        0:       flip_odds = 2;
        1:       flip_odds = 6;
        2:       flip_odds = 20;
        default: flip_odds = 60;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then run a stretch with both sides flat out
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        random_item();
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
